@@ sv/npr_pkg.sv @@
// ----------------------------------------------------------------------------
// npr_pkg: shared definitions for the nested region profiler
// Sizes, operation and status codes, sequencer states and field helpers.
// ----------------------------------------------------------------------------
package npr_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int STACK_DEPTH = 16;
    localparam int TOTAL_WIDTH = 48;

    localparam int TIMER_W = $clog2(NUM_TIMERS);
    localparam int PTR_W   = $clog2(STACK_DEPTH);
    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam int TICK_W  = 32;
    localparam int SUM_W   = ((TOTAL_WIDTH > TICK_W) ? TOTAL_WIDTH : TICK_W) + 1;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int FIELD_W  = 48;
    localparam int IN_W     = 8;
    localparam int OUT_W    = STATUS_W + IDX_W + FIELD_W + FIELD_W + 1;

    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_START      = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP_NAMED = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP_TOP   = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP_ALL   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ       = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STS_RUNNING     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_ACTIVE  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_STACK_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_STACK_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXCL,
        ST_INCL,
        ST_RESUME,
        ST_PUSH,
        ST_RESULT
    } state_t;

    function automatic logic [FIELD_W-1:0] to_field(input logic [TOTAL_WIDTH-1:0] total);
        logic [FIELD_W+TOTAL_WIDTH-1:0] ext;
        ext = {{FIELD_W{1'b0}}, total};
        return ext[FIELD_W-1:0];
    endfunction

endpackage

@@ sv/npr_sat_unit.sv @@
// ----------------------------------------------------------------------------
// npr_sat_unit: shared saturating time accumulator
// Adds the ticks elapsed since a begin mark to a total, sticking at the maximum.
// ----------------------------------------------------------------------------
module npr_sat_unit (
    input  logic [npr_pkg::TICK_W-1:0]      tick,
    input  logic [npr_pkg::TICK_W-1:0]      begin_mark,
    input  logic [npr_pkg::TOTAL_WIDTH-1:0] acc_in,
    output logic [npr_pkg::TOTAL_WIDTH-1:0] acc_out
);

    logic [npr_pkg::TICK_W-1:0] delta;
    logic [npr_pkg::SUM_W-1:0]  sum;

    assign delta = tick - begin_mark;
    assign sum   = npr_pkg::SUM_W'(acc_in) + npr_pkg::SUM_W'(delta);

    always_comb
    begin
        if (sum > npr_pkg::SUM_W'(npr_pkg::TOTAL_MAX))
        begin
            acc_out = npr_pkg::TOTAL_MAX;
        end
        else
        begin
            acc_out = sum[npr_pkg::TOTAL_WIDTH-1:0];
        end
    end

endmodule

@@ sv/nested_region_profiler_core.sv @@
// ----------------------------------------------------------------------------
// nested_region_profiler_core: hierarchical profiling timer block
// Nested timers on a stack with saturating inclusive and exclusive totals.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one transaction per command, and each
// command produces exactly one result transaction on the m_axis channel.
// The block works on one command at a time; s_axis_tready is high only while
// the sequencer is idle. All time accounting goes through a single saturating
// accumulator, one table update per cycle. A command is decoded first; tick,
// read, unused codes and every rejected command then go to the result. A start
// on an empty stack pushes; a start with a timer below it first updates that
// timer's exclusive total, then pushes. A stop updates the top timer's totals,
// pops and resumes the one below; stop all repeats until the stack is empty.
// The result sits in an output register, so the next command runs while a
// result waits; a stalled receiver only holds the sequencer when a second
// result is ready to be written. Reset clears the tick count, the stack level,
// the running flags and all totals; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nested_region_profiler_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // operation[2:0], timer_index[6:3], zero[7]
    input  logic [npr_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // status[2:0], affected_timer[6:3], inclusive_ticks[54:7],
    // exclusive_ticks[102:55], is_running[103]
    output logic [npr_pkg::OUT_W-1:0] m_axis_tdata
);

    npr_pkg::state_t state_reg, state_next;

    logic [npr_pkg::TICK_W-1:0]      tick_reg;
    logic [npr_pkg::LEVEL_W-1:0]     level_reg;
    logic [npr_pkg::TIMER_W-1:0]     stack_reg [npr_pkg::STACK_DEPTH];
    logic [npr_pkg::NUM_TIMERS-1:0]  running_reg;
    logic [npr_pkg::TICK_W-1:0]      incl_begin_reg [npr_pkg::NUM_TIMERS];
    logic [npr_pkg::TICK_W-1:0]      excl_begin_reg [npr_pkg::NUM_TIMERS];
    logic [npr_pkg::TOTAL_WIDTH-1:0] incl_total_reg [npr_pkg::NUM_TIMERS];
    logic [npr_pkg::TOTAL_WIDTH-1:0] excl_total_reg [npr_pkg::NUM_TIMERS];

    logic [npr_pkg::OP_W-1:0]        op_reg;
    logic [npr_pkg::IDX_W-1:0]       idx_reg;
    logic [npr_pkg::TIMER_W-1:0]     cur_t_reg;
    logic [npr_pkg::STATUS_W-1:0]    res_status_reg;
    logic [npr_pkg::IDX_W-1:0]       res_t_reg;
    logic                            res_show_reg;
    logic                            out_valid_reg;
    logic [npr_pkg::OUT_W-1:0]       out_data_reg;

    logic                        in_range;
    logic [npr_pkg::TIMER_W-1:0] idx_t;
    logic [npr_pkg::TIMER_W-1:0] top_t;
    logic [npr_pkg::TIMER_W-1:0] res_tt;
    logic                        level_zero;
    logic                        level_full;
    logic                        start_go;
    logic                        stop_go;
    logic                        out_free;

    logic                         tick_inc;
    logic                         cur_load;
    logic                         res_load;
    logic [npr_pkg::STATUS_W-1:0] res_status;
    logic [npr_pkg::IDX_W-1:0]    res_t;
    logic                         res_show;
    logic                         excl_wr;
    logic                         pop_en;
    logic                         push_en;
    logic                         resume_en;
    logic                         out_load;

    logic [npr_pkg::TOTAL_WIDTH-1:0] unit_acc;
    logic [npr_pkg::TICK_W-1:0]      unit_begin;
    logic [npr_pkg::TOTAL_WIDTH-1:0] unit_out;

    assign in_range   = 32'(idx_reg) < npr_pkg::NUM_TIMERS;
    assign idx_t      = npr_pkg::TIMER_W'(idx_reg);
    assign top_t      = stack_reg[npr_pkg::PTR_W'(level_reg - npr_pkg::LEVEL_W'(1))];
    assign res_tt     = npr_pkg::TIMER_W'(res_t_reg);
    assign level_zero = (level_reg == '0);
    assign level_full = (level_reg >= npr_pkg::LEVEL_W'(npr_pkg::STACK_DEPTH));
    assign start_go   = in_range && !running_reg[idx_t] && !level_full;
    assign out_free   = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        case (op_reg)
            npr_pkg::OP_STOP_NAMED: stop_go = in_range && !level_zero && (top_t == idx_t);
            npr_pkg::OP_STOP_TOP:   stop_go = !level_zero;
            npr_pkg::OP_STOP_ALL:   stop_go = !level_zero;
            default:                stop_go = 1'b0;
        endcase
    end

    assign unit_acc   = (state_reg == npr_pkg::ST_INCL) ? incl_total_reg[cur_t_reg]
                                                        : excl_total_reg[cur_t_reg];
    assign unit_begin = (state_reg == npr_pkg::ST_INCL) ? incl_begin_reg[cur_t_reg]
                                                        : excl_begin_reg[cur_t_reg];

    npr_sat_unit u_sat (
        .tick       (tick_reg),
        .begin_mark (unit_begin),
        .acc_in     (unit_acc),
        .acc_out    (unit_out)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            npr_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = npr_pkg::ST_DECODE;
                end
            end
            npr_pkg::ST_DECODE:
            begin
                if (op_reg == npr_pkg::OP_START && start_go)
                begin
                    state_next = level_zero ? npr_pkg::ST_PUSH : npr_pkg::ST_EXCL;
                end
                else if (stop_go)
                begin
                    state_next = npr_pkg::ST_EXCL;
                end
                else
                begin
                    state_next = npr_pkg::ST_RESULT;
                end
            end
            npr_pkg::ST_EXCL:
            begin
                state_next = (op_reg == npr_pkg::OP_START) ? npr_pkg::ST_PUSH
                                                           : npr_pkg::ST_INCL;
            end
            npr_pkg::ST_INCL:   state_next = npr_pkg::ST_RESUME;
            npr_pkg::ST_PUSH:   state_next = npr_pkg::ST_RESULT;
            npr_pkg::ST_RESUME:
            begin
                if (op_reg == npr_pkg::OP_STOP_ALL && !level_zero)
                begin
                    state_next = npr_pkg::ST_EXCL;
                end
                else
                begin
                    state_next = npr_pkg::ST_RESULT;
                end
            end
            npr_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = npr_pkg::ST_IDLE;
                end
            end
            default:            state_next = npr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        tick_inc   = 1'b0;
        cur_load   = 1'b0;
        res_load   = 1'b0;
        res_status = npr_pkg::STS_OK;
        res_t      = '0;
        res_show   = 1'b0;
        excl_wr    = 1'b0;
        pop_en     = 1'b0;
        push_en    = 1'b0;
        resume_en  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            npr_pkg::ST_DECODE:
            begin
                res_load = 1'b0;
                res_load = 1'b1;
                case (op_reg)
                    npr_pkg::OP_TICK:
                    begin
                        tick_inc = 1'b1;
                    end
                    npr_pkg::OP_START:
                    begin
                        res_t    = idx_reg;
                        res_show = in_range;
                        cur_load = start_go && !level_zero;
                        if (!in_range)
                        begin
                            res_status = npr_pkg::STS_NOT_ACTIVE;
                        end
                        else if (running_reg[idx_t])
                        begin
                            res_status = npr_pkg::STS_RUNNING;
                        end
                        else if (level_full)
                        begin
                            res_status = npr_pkg::STS_STACK_FULL;
                        end
                    end
                    npr_pkg::OP_STOP_NAMED:
                    begin
                        res_t      = idx_reg;
                        res_show   = in_range;
                        cur_load   = stop_go;
                        res_status = stop_go ? npr_pkg::STS_OK : npr_pkg::STS_NOT_ACTIVE;
                    end
                    npr_pkg::OP_STOP_TOP:
                    begin
                        cur_load   = stop_go;
                        res_show   = stop_go;
                        res_t      = stop_go ? npr_pkg::IDX_W'(top_t) : '0;
                        res_status = stop_go ? npr_pkg::STS_OK : npr_pkg::STS_STACK_EMPTY;
                    end
                    npr_pkg::OP_STOP_ALL:
                    begin
                        cur_load = stop_go;
                    end
                    npr_pkg::OP_READ:
                    begin
                        res_t      = idx_reg;
                        res_show   = in_range;
                        res_status = in_range ? npr_pkg::STS_OK : npr_pkg::STS_NOT_ACTIVE;
                    end
                    default:
                    begin
                        res_load = 1'b1;
                    end
                endcase
            end
            npr_pkg::ST_EXCL:   excl_wr = 1'b1;
            npr_pkg::ST_INCL:   pop_en = 1'b1;
            npr_pkg::ST_PUSH:   push_en = 1'b1;
            npr_pkg::ST_RESUME:
            begin
                resume_en = !level_zero;
                cur_load  = !level_zero;
            end
            npr_pkg::ST_RESULT: out_load = out_free;
            default:            out_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npr_pkg::ST_IDLE;
            tick_reg      <= '0;
            level_reg     <= '0;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < npr_pkg::NUM_TIMERS; i++)
            begin
                incl_total_reg[i] <= '0;
                excl_total_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (tick_inc)
            begin
                tick_reg <= tick_reg + npr_pkg::TICK_W'(1);
            end
            if (excl_wr)
            begin
                excl_total_reg[cur_t_reg] <= unit_out;
            end
            if (pop_en)
            begin
                incl_total_reg[cur_t_reg] <= unit_out;
                running_reg[cur_t_reg]    <= 1'b0;
                level_reg                 <= level_reg - npr_pkg::LEVEL_W'(1);
            end
            if (push_en)
            begin
                running_reg[idx_t] <= 1'b1;
                level_reg          <= level_reg + npr_pkg::LEVEL_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg  <= s_axis_tdata[npr_pkg::OP_W-1:0];
            idx_reg <= s_axis_tdata[npr_pkg::OP_W +: npr_pkg::IDX_W];
        end
        if (cur_load)
        begin
            cur_t_reg <= top_t;
        end
        if (res_load)
        begin
            res_status_reg <= res_status;
            res_t_reg      <= res_t;
            res_show_reg   <= res_show;
        end
        if (push_en)
        begin
            stack_reg[npr_pkg::PTR_W'(level_reg)] <= idx_t;
            incl_begin_reg[idx_t]                 <= tick_reg;
            excl_begin_reg[idx_t]                 <= tick_reg;
        end
        if (resume_en)
        begin
            excl_begin_reg[top_t] <= tick_reg;
        end
        if (out_load)
        begin
            if (res_show_reg)
            begin
                out_data_reg <= {running_reg[res_tt],
                                 npr_pkg::to_field(excl_total_reg[res_tt]),
                                 npr_pkg::to_field(incl_total_reg[res_tt]),
                                 res_t_reg, res_status_reg};
            end
            else
            begin
                out_data_reg <= {1'b0, {npr_pkg::FIELD_W{1'b0}}, {npr_pkg::FIELD_W{1'b0}},
                                 res_t_reg, res_status_reg};
            end
        end
    end

    assign s_axis_tready = (state_reg == npr_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= npr_pkg::LEVEL_W'(npr_pkg::STACK_DEPTH))
        else $error("Stack level exceeds the stack depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(running_reg) == 32'(level_reg))
        else $error("Running flags disagree with the stack level.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == npr_pkg::ST_EXCL |-> running_reg[cur_t_reg])
        else $error("Accumulating a timer that is not running.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == npr_pkg::ST_DECODE)
        else $error("Accepted transaction was not decoded.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !out_load)
        else $error("Result overwritten while the receiver stalls.");

endmodule
